>>> sv/mandelbrot_escape_pixel_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape pixel assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MEP_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MEP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Types, register indexes and the color palette ROM for the escape pixel block.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int CoordW = 10;
	localparam int FixW = 32;
	localparam int ColorW = 8;
	localparam int IterW = 11;

	// Configuration register indexes.
	localparam logic [1:0] REG_LEFT_EDGE = 2'd0;
	localparam logic [1:0] REG_TOP_EDGE = 2'd1;
	localparam logic [1:0] REG_X_STEP = 2'd2;
	localparam logic [1:0] REG_Y_STEP = 2'd3;

	// Palette index of the first iteration count: (70 + 0) mod 255 + 1.
	localparam logic [ColorW-1:0] PAL_START = 8'd71;
	localparam logic [ColorW-1:0] PAL_LAST = 8'd255;
	localparam logic [ColorW-1:0] PAL_WRAP = 8'd1;

	typedef struct packed {
		logic signed [FixW-1:0] cx;
		logic signed [FixW-1:0] cy;
	} point_t;

	typedef struct packed {
		logic [ColorW-1:0] red;
		logic [ColorW-1:0] green;
		logic [ColorW-1:0] blue;
		logic [IterW-1:0]  iter_count;
		logic              inside_set;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} iter_state_t;

	typedef logic [3*ColorW-1:0] palette_t [256];

	localparam longint unsigned PAL_DEN = 64'd255 * 64'd255 * 64'd255;
	localparam longint unsigned PAL_DEN2 = 64'd2 * PAL_DEN;

	// Builds the palette once at elaboration; entry k is {red, green, blue}.
	function automatic palette_t build_palette();
		palette_t       p;
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		longint unsigned g;
		longint unsigned bl;
		for (int k = 0; k < 256; k++) begin
			a = longint'(k);
			b = 64'd255 - a;
			r = (64'd9 * b * a * a * a) / PAL_DEN;
			g = (64'd15 * b * b * a * a) / PAL_DEN;
			bl = (64'd17 * b * b * b * a) / PAL_DEN2;
			p[k] = {r[7:0], g[7:0], bl[7:0]};
		end
		return p;
	endfunction

	localparam palette_t PALETTE = build_palette();

endpackage

>>> sv/mandelbrot_escape_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Pixels run one at a time through the shared iteration loop, a multiply
// state and an add/compare state per iteration; the next pixel is taken
// from the input queue only after the last result enters the result queue.
// Reset: arst_n clears queues and control at once; registers return to the
// default view of the plane.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
	parameter int ITER_LIMIT = 1024,
	parameter int FRAC_BITS = 28
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [mep_pkg::CoordW-1:0]      pixel_col,
	input  logic [mep_pkg::CoordW-1:0]      pixel_row,
	output logic                            empty,
	input  logic                            pop,
	output logic [mep_pkg::ColorW-1:0]      red,
	output logic [mep_pkg::ColorW-1:0]      green,
	output logic [mep_pkg::ColorW-1:0]      blue,
	output logic [mep_pkg::IterW-1:0]       iter_count,
	output logic                            inside_set,
	input  logic                            cfg_wen,
	input  logic [1:0]                      cfg_idx,
	input  logic [mep_pkg::FixW-1:0]        cfg_wdata
);
	import mep_pkg::*;

	`include "mandelbrot_escape_pixel_defines.svh"

	localparam int QueueDepth = 2;
	localparam logic [31:0] LimitWord = 32'(ITER_LIMIT);

	logic [FixW-1:0] left_edge_q;
	logic [FixW-1:0] top_edge_q;
	logic [FixW-1:0] x_step_q;
	logic [FixW-1:0] y_step_q;

	point_t  front_point;
	point_t  mid_point;
	q_stat_t mid_stat;
	logic    mid_pop;
	result_t res_in;
	result_t res_out;
	q_stat_t res_stat;
	logic    res_push;
	logic    out_black;
	logic    limit_count_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q <= 32'hE000_0000;
			top_edge_q <= 32'hEC00_0000;
			x_step_q <= 32'd786432;
			y_step_q <= 32'd873813;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_LEFT_EDGE: left_edge_q <= cfg_wdata;
				REG_TOP_EDGE:  top_edge_q <= cfg_wdata;
				REG_X_STEP:    x_step_q <= cfg_wdata;
				REG_Y_STEP:    y_step_q <= cfg_wdata;
				default:       left_edge_q <= left_edge_q;
			endcase
		end
	end

	mep_front u_front (
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.left_edge (left_edge_q),
		.top_edge  (top_edge_q),
		.x_step    (x_step_q),
		.y_step    (y_step_q),
		.point     (front_point)
	);

	mep_fifo #(
		.WIDTH ($bits(point_t)),
		.DEPTH (QueueDepth)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_point),
		.pop    (mid_pop),
		.rdata  (mid_point),
		.stat   (mid_stat)
	);

	assign full = mid_stat.full;

	mep_iter #(
		.ITER_LIMIT (ITER_LIMIT),
		.FRAC_BITS  (FRAC_BITS)
	) u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (mid_point),
		.in_stat  (mid_stat),
		.in_pop   (mid_pop),
		.out_stat (res_stat),
		.out_push (res_push),
		.result   (res_in)
	);

	mep_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QueueDepth)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.stat   (res_stat)
	);

	assign empty = res_stat.empty;
	assign red = res_out.red;
	assign green = res_out.green;
	assign blue = res_out.blue;
	assign iter_count = res_out.iter_count;
	assign inside_set = res_out.inside_set;

	assign out_black = (red == '0) && (green == '0) && (blue == '0);
	assign limit_count_ok = (res_in.iter_count == LimitWord[IterW-1:0]);

	`MEP_ASSERT_IMPLY(a_inside_black, !empty && inside_set, out_black, "inside pixel not black")
	`MEP_ASSERT_IMPLY(a_inside_count, res_push && res_in.inside_set, limit_count_ok, "bad count")
	`MEP_ASSERT_IMPLY(a_push_room, res_push, !res_stat.full, "result beat pushed into full queue")
	`MEP_ASSERT_NEXT(a_no_push_after_pop, mid_pop, !res_push && !mid_pop, "beat after pixel start")

endmodule

>>> sv/mep_fifo.sv
// ----------------------------------------------------------------------------
// mep_fifo
// Small register queue with full and empty flags; decouples two stages.
// ----------------------------------------------------------------------------
module mep_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output mep_pkg::q_stat_t stat
);
	import mep_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = (cnt_q == CntFull);
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/mep_front.sv
// ----------------------------------------------------------------------------
// mep_front
// Maps a pixel coordinate to its point c in the complex plane.
// ----------------------------------------------------------------------------
module mep_front (
	input  logic [mep_pkg::CoordW-1:0]     pixel_col,
	input  logic [mep_pkg::CoordW-1:0]     pixel_row,
	input  logic [mep_pkg::FixW-1:0]       left_edge,
	input  logic [mep_pkg::FixW-1:0]       top_edge,
	input  logic [mep_pkg::FixW-1:0]       x_step,
	input  logic [mep_pkg::FixW-1:0]       y_step,
	output mep_pkg::point_t                point
);
	import mep_pkg::*;

	logic [FixW-1:0] mul_x;
	logic [FixW-1:0] mul_y;

	// Only the low word of each product matters, since c wraps to 32 bits.
	assign mul_x = x_step * FixW'(pixel_col);
	assign mul_y = y_step * FixW'(pixel_row);

	assign point.cx = $signed(left_edge + mul_x);
	assign point.cy = $signed(top_edge + mul_y);

endmodule

>>> sv/mep_iter.sv
// ----------------------------------------------------------------------------
// mep_iter
// Escape-time iteration engine: z = z*z + c, a multiply and an add/compare state
// per iteration, then palette lookup and hand-off to the result queue.
// ----------------------------------------------------------------------------
module mep_iter #(
	parameter int ITER_LIMIT = 1024,
	parameter int FRAC_BITS = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mep_pkg::point_t  point,
	input  mep_pkg::q_stat_t in_stat,
	output logic             in_pop,
	input  mep_pkg::q_stat_t out_stat,
	output logic             out_push,
	output mep_pkg::result_t result
);
	import mep_pkg::*;

	localparam int CntW = $clog2(ITER_LIMIT + 1);
	localparam logic [CntW-1:0] CntLimit = CntW'(ITER_LIMIT);
	localparam int SqW = 2 * FixW;
	localparam logic [SqW:0] FourFix = (SqW + 1)'(4) << FRAC_BITS;

	iter_state_t            state_q;
	iter_state_t            state_d;
	logic signed [FixW-1:0] zx_q;
	logic signed [FixW-1:0] zy_q;
	logic signed [FixW-1:0] cx_q;
	logic signed [FixW-1:0] cy_q;
	logic [CntW-1:0]        cnt_q;
	logic [ColorW-1:0]      pal_q;
	logic                   inside_q;
	logic [SqW-1:0]         sqx_q;
	logic [SqW-1:0]         sqy_q;
	logic signed [SqW-1:0]  pxy_q;

	logic signed [SqW-1:0]  sqx_d;
	logic signed [SqW-1:0]  sqy_d;
	logic signed [SqW-1:0]  pxy_d;
	logic [SqW-1:0]         xx;
	logic [SqW-1:0]         yy;
	logic [SqW:0]           mag2;
	logic                   escaped;
	logic signed [SqW-1:0]  pxy_sh;
	logic [FixW-1:0]        zx_next;
	logic [FixW-1:0]        zy_next;
	logic                   at_limit;
	logic [3*ColorW-1:0]    rgb;
	logic [31:0]            cnt_ext;

	assign sqx_d = zx_q * zx_q;
	assign sqy_d = zy_q * zy_q;
	assign pxy_d = zx_q * zy_q;

	// Squares are never negative, so a logical shift is the floor.
	assign xx = sqx_q >> FRAC_BITS;
	assign yy = sqy_q >> FRAC_BITS;
	assign mag2 = {1'b0, xx} + {1'b0, yy};
	assign escaped = (mag2 >= FourFix);
	assign pxy_sh = pxy_q >>> (FRAC_BITS - 1);
	assign zx_next = xx[FixW-1:0] - yy[FixW-1:0] + cx_q;
	assign zy_next = pxy_sh[FixW-1:0] + cy_q;
	assign at_limit = (cnt_q == CntLimit);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!in_stat.empty) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = at_limit ? ST_DONE : ST_ADD;
			end
			ST_ADD: begin
				state_d = escaped ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_stat.full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_pop = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			ST_IDLE: in_pop = !in_stat.empty;
			ST_DONE: out_push = !out_stat.full;
			default: begin
				in_pop = 1'b0;
				out_push = 1'b0;
			end
		endcase
	end

	assign rgb = PALETTE[pal_q];
	assign cnt_ext = 32'(cnt_q);
	assign result.red = inside_q ? '0 : rgb[3*ColorW-1:2*ColorW];
	assign result.green = inside_q ? '0 : rgb[2*ColorW-1:ColorW];
	assign result.blue = inside_q ? '0 : rgb[ColorW-1:0];
	assign result.iter_count = cnt_ext[IterW-1:0];
	assign result.inside_set = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!in_stat.empty) begin
					cx_q <= point.cx;
					cy_q <= point.cy;
					zx_q <= '0;
					zy_q <= '0;
					cnt_q <= '0;
					pal_q <= PAL_START;
				end
			end
			ST_MUL: begin
				sqx_q <= sqx_d;
				sqy_q <= sqy_d;
				pxy_q <= pxy_d;
				inside_q <= at_limit;
			end
			ST_ADD: begin
				if (!escaped) begin
					zx_q <= $signed(zx_next);
					zy_q <= $signed(zy_next);
					cnt_q <= cnt_q + 1'b1;
					// The palette index follows (70 + i) mod 255 + 1 step by step.
					pal_q <= (pal_q == PAL_LAST) ? PAL_WRAP : pal_q + 1'b1;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

>>> tb/tb_mandelbrot_escape_pixel.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel
// Self-checking bench for the escape-time pixel unit. Pixels are pushed under
// a series of plane views (reset view, extreme and zero registers, random
// windows and registers, deep zooms). An in-bench escape-time model or a fixed
// probe result gives each color and iteration count; beats are checked in order.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel;
	import mep_pkg::*;

	localparam int MAX_ITERS = 1024;
	localparam int FRAC = 28;
	localparam longint ESCAPE_SQ = longint'(4) <<< FRAC;
	localparam int QUIET_LIMIT = 20000;

	localparam result_t NO_COLOR = '0;
	localparam result_t INSIDE_BLACK = {8'd0, 8'd0, 8'd0, 11'(MAX_ITERS), 1'b1};

	typedef struct packed {
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic              typed;
		result_t           want;
	} probe_t;

	typedef enum int {VIEW_WINDOW, VIEW_WILD, VIEW_ZOOM} view_kind_t;

	// Probes under the reset view. Rows on the real axis at columns 683, 512
	// and 341 sit in the main cardioid or the period-two bulb, so they are black.
	localparam probe_t PROBES [16] = '{
		{10'd0,     10'd0,     1'b0, NO_COLOR},
		{10'd1023,  10'd0,     1'b0, NO_COLOR},
		{10'd0,     10'd767,   1'b0, NO_COLOR},
		{10'd1023,  10'd767,   1'b0, NO_COLOR},
		{10'd1023,  10'd1023,  1'b0, NO_COLOR},
		{10'd0,     10'd1023,  1'b0, NO_COLOR},
		{10'd683,   10'd384,   1'b1, INSIDE_BLACK},
		{10'd512,   10'd384,   1'b1, INSIDE_BLACK},
		{10'd341,   10'd384,   1'b1, INSIDE_BLACK},
		{10'd170,   10'd384,   1'b0, NO_COLOR},
		{10'd1000,  10'd384,   1'b0, NO_COLOR},
		{10'h2AA,   10'h155,   1'b0, NO_COLOR},
		{10'h155,   10'h2AA,   1'b0, NO_COLOR},
		{10'd600,   10'd200,   1'b0, NO_COLOR},
		{10'd450,   10'd500,   1'b0, NO_COLOR},
		{10'd700,   10'd300,   1'b0, NO_COLOR}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [CoordW-1:0]    pixel_col;
	logic [CoordW-1:0]    pixel_row;
	logic                 empty;
	logic                 pop;
	logic [ColorW-1:0]    red;
	logic [ColorW-1:0]    green;
	logic [ColorW-1:0]    blue;
	logic [IterW-1:0]     iter_count;
	logic                 inside_set;
	logic                 cfg_wen;
	logic [1:0]           cfg_idx;
	logic [FixW-1:0]      cfg_wdata;

	// Current view of the plane as the predictor sees it.
	logic signed [FixW-1:0] view_left;
	logic signed [FixW-1:0] view_top;
	logic signed [FixW-1:0] view_dx;
	logic signed [FixW-1:0] view_dy;

	result_t pending_colors [$];
	result_t oldest;
	bit      calm;
	int      errors;
	int      pixels_sent;
	int      pixels_checked;
	int      inside_count;
	int      deepest_escape;
	int      views;
	int      quiet;
	int      r_left;
	int      r_top;
	int      r_dx;
	int      r_dy;
	view_kind_t kind;

	mandelbrot_escape_pixel #(
		.ITER_LIMIT(MAX_ITERS),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue),
		.iter_count(iter_count),
		.inside_set(inside_set),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic longint wrap_fix(input longint v);
		logic signed [FixW-1:0] t;
		t = v[FixW-1:0];
		return t;
	endfunction

	// Escape-time prediction for one pixel under the current view.
	function automatic result_t escape_pixel(input logic [CoordW-1:0] col,
			input logic [CoordW-1:0] row);
		longint          cx;
		longint          cy;
		longint          zx;
		longint          zy;
		longint          xx;
		longint          yy;
		longint          nx;
		longint          c_col;
		longint          c_row;
		longint unsigned a;
		longint unsigned b;
		longint unsigned chan;
		longint unsigned den;
		int              n;
		result_t         r;
		c_col = longint'(col);
		c_row = longint'(row);
		cx = wrap_fix(longint'(view_left) + c_col * longint'(view_dx));
		cy = wrap_fix(longint'(view_top) + c_row * longint'(view_dy));
		zx = 0;
		zy = 0;
		n = 0;
		while (n < MAX_ITERS) begin
			xx = (zx * zx) >>> FRAC;
			yy = (zy * zy) >>> FRAC;
			if (xx + yy >= ESCAPE_SQ)
				break;
			nx = wrap_fix(xx - yy + cx);
			zy = wrap_fix(((zx * zy) >>> (FRAC - 1)) + cy);
			zx = nx;
			n++;
		end
		r = NO_COLOR;
		r.iter_count = n[IterW-1:0];
		if (n >= MAX_ITERS) begin
			r.inside_set = 1'b1;
		end else begin
			a = 64'((70 + n) % 255 + 1);
			b = 64'd255 - a;
			den = 64'(255 * 255 * 255);
			chan = (9 * b * a * a * a) / den;
			r.red = chan[ColorW-1:0];
			chan = (15 * b * b * a * a) / den;
			r.green = chan[ColorW-1:0];
			chan = (17 * b * b * b * a) / (2 * den);
			r.blue = chan[ColorW-1:0];
		end
		return r;
	endfunction

	task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row,
			input bit typed, input result_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		pixel_col <= col;
		pixel_row <= row;
		do @(posedge clk); while (full);
		pending_colors.push_back(typed ? want : escape_pixel(col, row));
		pixels_sent++;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(CoordW'($urandom_range(1023)), CoordW'($urandom_range(1023)),
				1'b0, NO_COLOR);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [FixW-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
	endtask

	// Registers only change once every pending pixel has come back.
	task automatic set_view(input logic [FixW-1:0] left, input logic [FixW-1:0] top,
			input logic [FixW-1:0] dx, input logic [FixW-1:0] dy);
		drain();
		write_reg(REG_LEFT_EDGE, left);
		write_reg(REG_TOP_EDGE, top);
		write_reg(REG_X_STEP, dx);
		write_reg(REG_Y_STEP, dy);
		@(negedge clk);
		cfg_wen <= 1'b0;
		view_left = left;
		view_top = top;
		view_dx = dx;
		view_dy = dy;
		views++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(negedge clk)
		pop <= calm || ($urandom_range(99) >= 15);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_colors.size() == 0) begin
				errors++;
				$display("%0t: beat with no pixel pending, expected none, got iter_count %0d",
					$time, iter_count);
			end else begin
				oldest = pending_colors.pop_front();
				compare_field("red", 32'(oldest.red), 32'(red));
				compare_field("green", 32'(oldest.green), 32'(green));
				compare_field("blue", 32'(oldest.blue), 32'(blue));
				compare_field("iter_count", 32'(oldest.iter_count), 32'(iter_count));
				compare_field("inside_set", 32'(oldest.inside_set), 32'(inside_set));
				pixels_checked++;
				if (oldest.inside_set)
					inside_count++;
				else if (oldest.iter_count > deepest_escape)
					deepest_escape = int'(oldest.iter_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, quiet);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pixel_col = '0;
		pixel_row = '0;
		cfg_wen = 1'b0;
		cfg_idx = REG_LEFT_EDGE;
		cfg_wdata = '0;
		calm = 1'b0;
		view_left = 32'hE000_0000;
		view_top = 32'hEC00_0000;
		view_dx = 32'd786432;
		view_dy = 32'd873813;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset view: probes first, then random pixels with a stretch of no idling.
		foreach (PROBES[i])
			send_pixel(PROBES[i].col, PROBES[i].row, PROBES[i].typed, PROBES[i].want);
		send_random(50);
		calm = 1'b1;
		send_random(80);
		calm = 1'b0;
		send_random(20);

		// Register extremes; the points wrap, so some escape at once and others sit near the origin.
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_pixel(10'd0, 10'd0, 1'b0, NO_COLOR);
		send_pixel(10'd1023, 10'd1023, 1'b0, NO_COLOR);
		send_random(18);
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pixel(10'd0, 10'd0, 1'b0, NO_COLOR);
		send_pixel(10'd1023, 10'd1023, 1'b0, NO_COLOR);
		send_random(18);

		// A zero view puts every pixel at the origin, so each one runs to the limit.
		set_view('0, '0, '0, '0);
		send_pixel(10'd0, 10'd0, 1'b0, INSIDE_BLACK);
		send_pixel(10'd1023, 10'd1023, 1'b1, INSIDE_BLACK);
		send_random(4);

		for (int p = 0; p < 7; p++) begin
			kind = view_kind_t'(p % 3);
			case (kind)
				VIEW_WINDOW: begin
					r_left = -int'($urandom_range(671088640));
					r_top = -int'($urandom_range(402653184));
					r_dx = int'($urandom_range(1 << 20, 1 << 12));
					r_dy = int'($urandom_range(1 << 20, 1 << 12));
					if ($urandom_range(3) == 0)
						r_dx = -r_dx;
					if ($urandom_range(3) == 0)
						r_dy = -r_dy;
				end
				VIEW_WILD: begin
					r_left = $urandom;
					r_top = $urandom;
					r_dx = $urandom;
					r_dy = $urandom;
				end
				default: begin
					r_left = -201326592 + int'($urandom_range(1 << 25)) - (1 << 24);
					r_top = int'($urandom_range(1 << 27)) - (1 << 26);
					r_dx = int'($urandom_range(1 << 12, 1));
					r_dy = int'($urandom_range(1 << 12, 1));
				end
			endcase
			set_view(r_left, r_top, r_dx, r_dy);
			send_random(40);
		end

		drain();
		repeat (2 * MAX_ITERS + 8) @(posedge clk);
		$display("Pushed %0d pixels under %0d programmed views, checked %0d beats.",
			pixels_sent, views, pixels_checked);
		$display("%0d pixels hit the iteration limit; deepest escape took %0d iterations.",
			inside_count, deepest_escape);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/mep_pkg.sv
sv/mep_fifo.sv
sv/mep_front.sv
sv/mep_iter.sv
sv/mandelbrot_escape_pixel.sv
tb/tb_mandelbrot_escape_pixel.sv
